/* hdl/bpa_pkg.sv */
// ----------------------------------------------------------------------------
// bpa_pkg
// Types, codes and constants shared by the bitmap page allocator modules.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int REG_W = 13;   // configuration register width
    localparam int IDX_W = 12;   // block index width on the streams

    localparam logic [REG_W-1:0] TOTAL_BLOCKS_RST    = 13'd4096;
    localparam logic [REG_W-1:0] RESERVED_BLOCKS_RST = 13'd1;

    // first block of a map byte sits in its MSB
    localparam logic [7:0] BIT0_MASK = 8'b10000000;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_NOT_ALLOCATED = 2'd1,
        ST_OUT_OF_RANGE  = 2'd2,
        ST_OUT_OF_MEMORY = 2'd3
    } status_t;

    typedef enum logic {
        CFG_TOTAL_BLOCKS    = 1'b0,
        CFG_RESERVED_BLOCKS = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_EVAL,
        S_FREE_RD,
        S_FREE_EVAL,
        S_DONE
    } state_t;

    // result of one byte scan
    typedef struct packed {
        logic             hit;       // free block below the limit found
        logic             oom;       // limit reached, nothing left
        logic [REG_W-1:0] blk;       // granted block on hit
        logic [REG_W-1:0] next_cur;  // cursor after this byte
        logic [7:0]       set_data;  // byte with the granted bit marked
    } scan_res_t;

    function automatic logic [7:0] bit_mask(input logic [2:0] off);
        return BIT0_MASK >> off;
    endfunction

endpackage

/* hdl/bpa_ram.sv */
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/bpa_scan.sv */
// ----------------------------------------------------------------------------
// bpa_scan
// Byte scanner: finds the first clear bit at or after the cursor inside one
// map byte and checks it, or the next byte start, against the limit.
// ----------------------------------------------------------------------------
module bpa_scan (
    input  logic [7:0]                rd_data,
    input  logic [bpa_pkg::REG_W-1:0] cursor,
    input  logic [bpa_pkg::REG_W-1:0] lim,
    output bpa_pkg::scan_res_t        res
);

    logic [7:0]                  free_vec;
    logic                        found;
    logic [2:0]                  k_sel;
    logic [bpa_pkg::REG_W-1:0]   cand;
    logic [bpa_pkg::REG_W:0]     next_wide;
    logic                        hit;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            free_vec[k] = !rd_data[3'(7 - k)] && (3'(k) >= cursor[2:0]);
        end
        found = 1'b0;
        k_sel = 3'd0;
        for (int k = 7; k >= 0; k--) begin
            if (free_vec[k]) begin
                found = 1'b1;
                k_sel = 3'(k);
            end
        end
    end

    assign cand      = {cursor[bpa_pkg::REG_W-1:3], k_sel};
    assign next_wide = {1'b0, cursor[bpa_pkg::REG_W-1:3], 3'b000} + (bpa_pkg::REG_W+1)'(8);
    assign hit       = found && (cand < lim);

    always_comb begin
        res.hit      = hit;
        // a free bit past the limit, or a next byte at or past it, ends the scan
        res.oom      = !hit && (found || (next_wide >= {1'b0, lim}));
        res.blk      = cand;
        res.next_cur = res.oom ? lim : next_wide[bpa_pkg::REG_W-1:0];
        res.set_data = rd_data | bpa_pkg::bit_mask(k_sel);
    end

endmodule

/* hdl/bitmap_page_allocator_unit.sv */
// ----------------------------------------------------------------------------
// bitmap_page_allocator_unit
// Next-fit page block allocator over a used-bit map held in RAM, one map
// byte scanned per pass of a single byte scanner.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | payload
//  s_       | in  | s_tvalid / s_tready  | tuser: operation; tdata: block_index
//  m_       | out | m_tvalid / m_tready  | tdata: result_block; tuser: status
//  cfg_     | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
//  Allocate: map bytes scanned from the cursor, one RAM read and one scanner
//  pass per byte; free: one map byte read, checked and, if set, cleared; a request
//  that fails its range check goes straight to the result. One request at a time.
//  After reset a clearing pass zeroes all MAP_BYTES map bytes, s_tready low
//  meanwhile. A held result stalls the next one.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_unit #(
    parameter int BLOCK_COUNT = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [11:0] block_index
    input  logic [0:0]  s_tuser,    // [0] operation

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [11:0] result_block
    output logic [1:0]  m_tuser,    // [1:0] status

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int REG_W     = bpa_pkg::REG_W;
    localparam int IDX_W     = bpa_pkg::IDX_W;
    localparam int LIM_CAP   = (BLOCK_COUNT > 8191) ? 8191 : BLOCK_COUNT;
    localparam int MAP_BYTES = (LIM_CAP + 7) / 8;
    localparam int ADDR_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam logic [REG_W-1:0]  CAP_BLOCKS = REG_W'(LIM_CAP);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(MAP_BYTES - 1);

    bpa_pkg::state_t  state_reg, state_next;

    logic [REG_W-1:0] total_reg, reserved_reg;
    logic [REG_W-1:0] cursor_reg, cursor_next;
    logic [REG_W-1:0] req_blk_reg, req_blk_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [IDX_W-1:0] res_blk_reg, res_blk_next;
    bpa_pkg::status_t res_st_reg, res_st_next;
    logic [IDX_W-1:0] out_blk_reg, out_blk_next;
    bpa_pkg::status_t out_st_reg, out_st_next;
    logic             m_tvalid_reg, m_tvalid_next;

    logic [REG_W-1:0] lim;
    logic [REG_W-1:0] cur_eff;
    logic [REG_W-1:0] in_blk;
    logic             in_acc;
    logic             in_alloc;
    logic             free_bad;
    logic             alloc_full;
    logic             out_free;
    logic             free_used;
    logic [7:0]       free_mask;
    logic [REG_W-4:0] cur_byte, req_byte;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_rdata;

    bpa_pkg::scan_res_t scan;

    assign lim        = (total_reg < CAP_BLOCKS) ? total_reg : CAP_BLOCKS;
    assign cur_eff    = (cursor_reg < reserved_reg) ? reserved_reg : cursor_reg;
    assign in_blk     = {1'b0, s_tdata[IDX_W-1:0]};
    assign in_acc     = s_tvalid && s_tready;
    assign in_alloc   = (s_tuser[0] == bpa_pkg::OP_ALLOC);
    assign free_bad   = (in_blk >= lim) || (in_blk < reserved_reg);
    assign alloc_full = (cur_eff >= lim);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign cur_byte   = cursor_reg[REG_W-1:3];
    assign req_byte   = req_blk_reg[REG_W-1:3];
    assign free_mask  = bpa_pkg::bit_mask(req_blk_reg[2:0]);
    assign free_used  = |(ram_rdata & free_mask);

    assign s_tready  = (state_reg == bpa_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {4'b0000, out_blk_reg};
    assign m_tuser   = out_st_reg;

    bpa_ram #(
        .WIDTH (8),
        .DEPTH (MAP_BYTES),
        .ADDR_W(ADDR_W)
    ) u_map (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    bpa_scan u_scan (
        .rd_data(ram_rdata),
        .cursor (cursor_reg),
        .lim    (lim),
        .res    (scan)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bpa_pkg::S_CLEAR: begin
                if (clr_addr_reg == LAST_ADDR) state_next = bpa_pkg::S_IDLE;
            end
            bpa_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (in_alloc) begin
                        state_next = alloc_full ? bpa_pkg::S_DONE : bpa_pkg::S_ALLOC_RD;
                    end else begin
                        state_next = free_bad ? bpa_pkg::S_DONE : bpa_pkg::S_FREE_RD;
                    end
                end
            end
            bpa_pkg::S_ALLOC_RD:   state_next = bpa_pkg::S_ALLOC_EVAL;
            bpa_pkg::S_ALLOC_EVAL: begin
                if (scan.hit || scan.oom) state_next = bpa_pkg::S_DONE;
                else                      state_next = bpa_pkg::S_ALLOC_RD;
            end
            bpa_pkg::S_FREE_RD:    state_next = bpa_pkg::S_FREE_EVAL;
            bpa_pkg::S_FREE_EVAL:  state_next = bpa_pkg::S_DONE;
            bpa_pkg::S_DONE: begin
                if (out_free) state_next = bpa_pkg::S_IDLE;
            end
            default:               state_next = bpa_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        cursor_next   = cursor_reg;
        req_blk_next  = req_blk_reg;
        clr_addr_next = clr_addr_reg;
        res_blk_next  = res_blk_reg;
        res_st_next   = res_st_reg;
        out_blk_next  = out_blk_reg;
        out_st_next   = out_st_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        ram_we        = 1'b0;
        ram_waddr     = cur_byte[ADDR_W-1:0];
        ram_wdata     = scan.set_data;
        ram_raddr     = cur_byte[ADDR_W-1:0];

        unique case (state_reg)
            bpa_pkg::S_CLEAR: begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = 8'h00;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            bpa_pkg::S_IDLE: begin
                if (in_acc) begin
                    req_blk_next = in_blk;
                    res_blk_next = '0;
                    if (in_alloc) begin
                        cursor_next = cur_eff;
                        res_st_next = bpa_pkg::ST_OUT_OF_MEMORY;
                    end else begin
                        res_st_next = bpa_pkg::ST_OUT_OF_RANGE;
                    end
                end
            end
            bpa_pkg::S_ALLOC_RD: begin
                ram_raddr = cur_byte[ADDR_W-1:0];
            end
            bpa_pkg::S_ALLOC_EVAL: begin
                if (scan.hit) begin
                    ram_we       = 1'b1;
                    cursor_next  = scan.blk + REG_W'(1);
                    res_blk_next = scan.blk[IDX_W-1:0];
                    res_st_next  = bpa_pkg::ST_OK;
                end else begin
                    cursor_next  = scan.next_cur;
                    res_st_next  = bpa_pkg::ST_OUT_OF_MEMORY;
                end
            end
            bpa_pkg::S_FREE_RD: begin
                ram_raddr = req_byte[ADDR_W-1:0];
            end
            bpa_pkg::S_FREE_EVAL: begin
                ram_waddr = req_byte[ADDR_W-1:0];
                ram_wdata = ram_rdata & ~free_mask;
                if (free_used) begin
                    ram_we       = 1'b1;
                    res_blk_next = req_blk_reg[IDX_W-1:0];
                    res_st_next  = bpa_pkg::ST_OK;
                end else begin
                    res_st_next  = bpa_pkg::ST_NOT_ALLOCATED;
                end
            end
            bpa_pkg::S_DONE: begin
                if (out_free) begin
                    out_blk_next  = res_blk_reg;
                    out_st_next   = res_st_reg;
                    m_tvalid_next = 1'b1;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bpa_pkg::S_CLEAR;
            clr_addr_reg <= '0;
            cursor_reg   <= bpa_pkg::RESERVED_BLOCKS_RST;
            total_reg    <= bpa_pkg::TOTAL_BLOCKS_RST;
            reserved_reg <= bpa_pkg::RESERVED_BLOCKS_RST;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            cursor_reg   <= cursor_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index[0])
                    bpa_pkg::CFG_TOTAL_BLOCKS:    total_reg    <= cfg_data;
                    bpa_pkg::CFG_RESERVED_BLOCKS: reserved_reg <= cfg_data;
                    default:                      total_reg    <= total_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_blk_reg <= req_blk_next;
        res_blk_reg <= res_blk_next;
        res_st_reg  <= res_st_next;
        out_blk_reg <= out_blk_next;
        out_st_reg  <= out_st_next;
    end

endmodule
